[sv/ssac_pkg.sv]
// Shared constants, codes and types of the split set associative cache tag block.
`timescale 1ns / 1ps
`default_nettype none

package ssac_pkg;

    // Parameter defaults
    localparam int MAX_LINES_DEF   = 1024;
    localparam int MAX_WAYS_DEF    = 8;
    localparam int ADDR_WIDTH_DEF  = 32;
    localparam int STAMP_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int FUNC_W     = 2;
    localparam int WAY_W      = 3;
    localparam int CNT_W      = 32;
    localparam int MIN_OFFSET = 4;
    localparam int LFSR_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int RES_BITS   = 1 + WAY_W + 1 + 5 * CNT_W;
    localparam int OUT_W      = ((RES_BITS + 7) / 8) * 8;

    // Access kinds
    localparam logic [FUNC_W-1:0] FUNC_DREAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DWRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_IFETCH = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 3'd4;

    // Configuration reset values
    localparam logic [2:0]        OFFSET_RST = 3'd4;
    localparam logic [3:0]        SETS_RST   = 4'd6;
    localparam logic [1:0]        WAYS_RST   = 2'd0;
    localparam logic              POLICY_RST = 1'b0;
    localparam logic [LFSR_W-1:0] SEED_RST   = 16'd1;

    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_LAST,
        ST_WRITE,
        ST_OUT
    } state_t;

    // Outcome of one sweep over the ways of a set
    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             hit_dirty;
        logic [WAY_W-1:0] lru_way;
        logic             lru_dirty;
        logic             rnd_dirty;
    } scan_res_t;

    // Counter bump requests
    typedef struct packed {
        logic dmiss;
        logic imiss;
        logic wb;
        logic dacc;
        logic iacc;
    } cnt_evt_t;

    typedef struct packed {
        logic [CNT_W-1:0] iacc;
        logic [CNT_W-1:0] dacc;
        logic [CNT_W-1:0] wb;
        logic [CNT_W-1:0] imiss;
        logic [CNT_W-1:0] dmiss;
    } cnt_val_t;

endpackage

`default_nettype wire

[sv/ssac_tag_ram.sv]
// Tag store memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ssac_tag_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 62
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/ssac_way_scan.sv]
// Shared compare unit: takes one way per beat, finds the hit and the replacement victim.
`timescale 1ns / 1ps
`default_nettype none

module ssac_way_scan #(
    parameter int TAG_W   = 28,
    parameter int STAMP_W = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       start,
    input  wire logic                       step,
    input  wire logic [ssac_pkg::WAY_W-1:0] way,
    input  wire logic                       line_valid,
    input  wire logic                       line_dirty,
    input  wire logic [TAG_W-1:0]           line_tag,
    input  wire logic [STAMP_W-1:0]         line_stamp,
    input  wire logic [TAG_W-1:0]           tag,
    input  wire logic [STAMP_W-1:0]         clock,
    input  wire logic [ssac_pkg::WAY_W-1:0] rnd_way,
    output ssac_pkg::scan_res_t             res
);

    ssac_pkg::scan_res_t res_reg;
    ssac_pkg::scan_res_t res_next;
    logic                inv_reg;
    logic                inv_next;
    logic [STAMP_W-1:0]  best_reg;
    logic [STAMP_W-1:0]  best_next;

    // Accumulate hit, LRU candidate and random-victim dirty bit
    always_comb begin
        res_next  = res_reg;
        inv_next  = inv_reg;
        best_next = best_reg;
        if (start) begin
            res_next  = '0;
            inv_next  = 1'b0;
            best_next = clock;
        end else if (step) begin
            // first valid matching way wins
            if (!res_reg.hit && line_valid && (line_tag == tag)) begin
                res_next.hit       = 1'b1;
                res_next.hit_way   = way;
                res_next.hit_dirty = line_dirty;
            end
            // lowest invalid way, else oldest stamp below the clock, else way 0
            if (!inv_reg) begin
                if (!line_valid) begin
                    inv_next           = 1'b1;
                    res_next.lru_way   = way;
                    res_next.lru_dirty = line_dirty;
                end else if (line_stamp < best_reg) begin
                    best_next          = line_stamp;
                    res_next.lru_way   = way;
                    res_next.lru_dirty = line_dirty;
                end else if (way == '0) begin
                    res_next.lru_dirty = line_dirty;
                end
            end
            if (way == rnd_way) begin
                res_next.rnd_dirty = line_dirty;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg  <= res_next;
        inv_reg  <= inv_next;
        best_reg <= best_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

[sv/ssac_counters.sv]
// Saturating miss, write-back and access counters.
`timescale 1ns / 1ps
`default_nettype none

module ssac_counters (
    input  wire logic               aclk,
    input  wire logic               clear,
    input  wire ssac_pkg::cnt_evt_t evt,
    output ssac_pkg::cnt_val_t      cnt
);

    ssac_pkg::cnt_val_t cnt_reg;
    ssac_pkg::cnt_val_t cnt_next;

    function automatic logic [ssac_pkg::CNT_W-1:0] sat_inc(
        input logic [ssac_pkg::CNT_W-1:0] v,
        input logic                       en
    );
        logic [ssac_pkg::CNT_W-1:0] r;
        r = v;
        if (en && (v != '1)) begin
            r = v + 1'b1;
        end
        return r;
    endfunction

    // Clear all counters, else bump each counter, hold at all ones
    always_comb begin
        if (clear) begin
            cnt_next = '0;
        end else begin
            cnt_next.dmiss = sat_inc(cnt_reg.dmiss, evt.dmiss);
            cnt_next.imiss = sat_inc(cnt_reg.imiss, evt.imiss);
            cnt_next.wb    = sat_inc(cnt_reg.wb, evt.wb);
            cnt_next.dacc  = sat_inc(cnt_reg.dacc, evt.dacc);
            cnt_next.iacc  = sat_inc(cnt_reg.iacc, evt.iacc);
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
    end

    assign cnt = cnt_reg;

endmodule

`default_nettype wire

[sv/split_set_assoc_cache_tags.sv]
// Top level: split instruction/data cache tag stores with a way-serial lookup sequencer.
//
//   channel   direction  payload (low bit first)                           beat taken when
//   s_axis    in         tdata: func[1:0], addr                            tvalid & tready
//   m_axis    out        tdata: hit, victim_way, writeback, data_misses,   tvalid & tready
//                               inst_misses, mem_writes, data_accesses,
//                               inst_accesses
//   cfg       in         cfg_index selects register, cfg_data holds value  cfg_valid & cfg_ready
//
// An access goes through a decode state, one tag memory read per way through the shared compare
// unit, then a compare, an update and a result state; an unused access kind goes from decode
// straight to the result state. The single tag memory read port serialises the ways.
// After reset and after every write to a listed register a clearing pass sweeps all
// 2 * 2**clog2(MAX_LINES) tag memory words (2048 by default); s_axis_tready
// stays low meanwhile. A write to an index outside the list changes nothing.
// Reset is synchronous, active low. A result waiting on m_axis stalls only the result state.
`timescale 1ns / 1ps
`default_nettype none

module split_set_assoc_cache_tags #(
    parameter int MAX_LINES   = ssac_pkg::MAX_LINES_DEF,
    parameter int MAX_WAYS    = ssac_pkg::MAX_WAYS_DEF,
    parameter int ADDR_WIDTH  = ssac_pkg::ADDR_WIDTH_DEF,
    parameter int STAMP_WIDTH = ssac_pkg::STAMP_WIDTH_DEF,
    localparam int IN_W = ((ADDR_WIDTH + ssac_pkg::FUNC_W + 7) / 8) * 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // func[1:0], addr[ADDR_WIDTH+1:2], zero fill above
    input  wire logic [IN_W-1:0]                     s_axis_tdata,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // hit[0], victim_way[3:1], writeback[4], data_misses[36:5], inst_misses[68:37],
    // mem_writes[100:69], data_accesses[132:101], inst_accesses[164:133], zero fill above
    output logic [ssac_pkg::OUT_W-1:0]               m_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ssac_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ssac_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int LINE_W   = $clog2(MAX_LINES);
    localparam int LINE_LOG = $clog2(MAX_LINES + 1) - 1;
    localparam int WAY_LOG  = $clog2(MAX_WAYS + 1) - 1;
    localparam int TAG_W    = ADDR_WIDTH - ssac_pkg::MIN_OFFSET;
    localparam int RAM_AW   = LINE_W + 1;
    localparam int WORD_W   = 2 + TAG_W + STAMP_WIDTH;
    localparam int WAY_W    = ssac_pkg::WAY_W;
    localparam int LFSR_W   = ssac_pkg::LFSR_W;
    localparam int PAD_W    = ssac_pkg::OUT_W - ssac_pkg::RES_BITS;

    function automatic logic [LFSR_W-1:0] lfsr_adv(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] r;
        r = v >> 1;
        if (v[0]) begin
            r = r ^ ssac_pkg::LFSR_TAPS;
        end
        return r;
    endfunction

    // Control registers
    ssac_pkg::state_t     state_reg,      state_next;
    logic [RAM_AW-1:0]    clr_idx_reg,    clr_idx_next;
    logic [2:0]           cfg_off_reg,    cfg_off_next;
    logic [3:0]           cfg_sets_reg,   cfg_sets_next;
    logic [1:0]           cfg_ways_reg,   cfg_ways_next;
    logic                 cfg_rand_reg,   cfg_rand_next;
    logic [LFSR_W-1:0]    cfg_seed_reg,   cfg_seed_next;
    logic                 m_valid_reg,    m_valid_next;
    logic                 cmp_vld_reg,    cmp_vld_next;

    // Payload registers
    logic [ssac_pkg::FUNC_W-1:0] func_reg,      func_next;
    logic [ADDR_WIDTH-1:0]       addr_reg,      addr_next;
    logic [LINE_W-1:0]           line_base_reg, line_base_next;
    logic [TAG_W-1:0]            tag_reg,       tag_next;
    logic                        is_data_reg,   is_data_next;
    logic [WAY_W-1:0]            rnd_way_reg,   rnd_way_next;
    logic [WAY_W-1:0]            rd_way_reg,    rd_way_next;
    logic [WAY_W-1:0]            cmp_way_reg,   cmp_way_next;
    logic [LFSR_W-1:0]           lfsr_reg,      lfsr_next;
    logic [STAMP_WIDTH-1:0]      clock_reg,     clock_next;
    logic                        res_hit_reg,   res_hit_next;
    logic [WAY_W-1:0]            res_way_reg,   res_way_next;
    logic                        res_wb_reg,    res_wb_next;
    logic [ssac_pkg::OUT_W-1:0]  out_reg,       out_next;

    // Geometry
    logic [2:0]        off_eff;
    logic [1:0]        w_eff;
    logic [4:0]        s_lim;
    logic [4:0]        s_eff;
    logic [4:0]        tag_shift;
    logic [LINE_W-1:0] set_mask;
    logic [LINE_W-1:0] set_val;
    logic [LINE_W-1:0] line_base;
    logic [TAG_W-1:0]  tag_val;
    logic [WAY_W-1:0]  ways_mask;

    // Memory and unit hookup
    logic              ram_we;
    logic [RAM_AW-1:0] ram_wa;
    logic [WORD_W-1:0] ram_wd;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_ra;
    logic [WORD_W-1:0] ram_rd;
    logic              scan_start;
    ssac_pkg::scan_res_t scan_res;
    ssac_pkg::cnt_evt_t  evt;
    ssac_pkg::cnt_val_t  cnt;
    logic              cnt_clear;

    // Update decision
    logic              upd_hit;
    logic [WAY_W-1:0]  upd_way;
    logic              upd_dirty;
    logic              upd_wb;
    logic              victim_dirty;
    logic              out_free;

    // Effective geometry from the configuration
    always_comb begin
        off_eff   = (cfg_off_reg < 3'(ssac_pkg::MIN_OFFSET)) ?
                    3'(ssac_pkg::MIN_OFFSET) : cfg_off_reg;
        w_eff     = (int'(cfg_ways_reg) > WAY_LOG) ? 2'(WAY_LOG) : cfg_ways_reg;
        s_lim     = 5'(LINE_LOG) - {3'b000, w_eff};
        s_eff     = ({1'b0, cfg_sets_reg} > s_lim) ? s_lim : {1'b0, cfg_sets_reg};
        tag_shift = {2'b00, off_eff} + s_eff;
        set_mask  = ~({LINE_W{1'b1}} << s_eff);
        set_val   = LINE_W'(addr_reg >> off_eff) & set_mask;
        line_base = set_val << w_eff;
        tag_val   = TAG_W'(addr_reg >> tag_shift);
        ways_mask = ~({WAY_W{1'b1}} << w_eff);
    end

    // Hit or victim, and the line to write back
    always_comb begin
        upd_hit      = scan_res.hit;
        victim_dirty = cfg_rand_reg ? scan_res.rnd_dirty : scan_res.lru_dirty;
        if (upd_hit) begin
            upd_way   = scan_res.hit_way;
            upd_dirty = scan_res.hit_dirty || (func_reg == ssac_pkg::FUNC_DWRITE);
            upd_wb    = 1'b0;
        end else begin
            upd_way   = cfg_rand_reg ? rnd_way_reg : scan_res.lru_way;
            upd_dirty = is_data_reg && (func_reg == ssac_pkg::FUNC_DWRITE);
            upd_wb    = is_data_reg && victim_dirty;
        end
    end

    assign out_free = !m_valid_reg || m_axis_tready;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        cfg_off_next   = cfg_off_reg;
        cfg_sets_next  = cfg_sets_reg;
        cfg_ways_next  = cfg_ways_reg;
        cfg_rand_next  = cfg_rand_reg;
        cfg_seed_next  = cfg_seed_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        cmp_vld_next   = 1'b0;
        func_next      = func_reg;
        addr_next      = addr_reg;
        line_base_next = line_base_reg;
        tag_next       = tag_reg;
        is_data_next   = is_data_reg;
        rnd_way_next   = rnd_way_reg;
        rd_way_next    = rd_way_reg;
        cmp_way_next   = cmp_way_reg;
        lfsr_next      = lfsr_reg;
        clock_next     = clock_reg;
        res_hit_next   = res_hit_reg;
        res_way_next   = res_way_reg;
        res_wb_next    = res_wb_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_wa         = {!is_data_reg, line_base_reg | LINE_W'(upd_way)};
        ram_wd         = {1'b1, upd_dirty, tag_reg, clock_reg};
        ram_re         = 1'b0;
        ram_ra         = {!is_data_reg, line_base_reg | LINE_W'(rd_way_reg)};
        scan_start     = 1'b0;
        evt            = '0;
        cnt_clear      = 1'b0;
        s_axis_tready  = 1'b0;

        unique case (state_reg)
            ssac_pkg::ST_CLEAR: begin
                // sweep every line invalid, reload clock, counters and LFSR
                ram_we       = 1'b1;
                ram_wa       = clr_idx_reg;
                ram_wd       = '0;
                cnt_clear    = 1'b1;
                clock_next   = '0;
                lfsr_next    = (cfg_seed_reg == '0) ? LFSR_W'(1) : cfg_seed_reg;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1) begin
                    state_next = ssac_pkg::ST_IDLE;
                end
            end
            ssac_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    func_next  = s_axis_tdata[ssac_pkg::FUNC_W-1:0];
                    addr_next  = s_axis_tdata[ssac_pkg::FUNC_W +: ADDR_WIDTH];
                    state_next = ssac_pkg::ST_DECODE;
                end
            end
            ssac_pkg::ST_DECODE: begin
                if (func_reg == ssac_pkg::FUNC_NONE) begin
                    res_hit_next = 1'b0;
                    res_way_next = '0;
                    res_wb_next  = 1'b0;
                    state_next   = ssac_pkg::ST_OUT;
                end else begin
                    line_base_next = line_base;
                    tag_next       = tag_val;
                    is_data_next   = (func_reg != ssac_pkg::FUNC_IFETCH);
                    rnd_way_next   = lfsr_reg[WAY_W-1:0] & ways_mask;
                    rd_way_next    = '0;
                    scan_start     = 1'b1;
                    state_next     = ssac_pkg::ST_SCAN;
                end
            end
            ssac_pkg::ST_SCAN: begin
                // issue one way per beat, compare it on the next
                ram_re       = 1'b1;
                cmp_vld_next = 1'b1;
                cmp_way_next = rd_way_reg;
                rd_way_next  = rd_way_reg + 1'b1;
                if (rd_way_reg == ways_mask) begin
                    state_next = ssac_pkg::ST_LAST;
                end
            end
            ssac_pkg::ST_LAST: begin
                state_next = ssac_pkg::ST_WRITE;
            end
            ssac_pkg::ST_WRITE: begin
                ram_we       = 1'b1;
                evt.dmiss    = !upd_hit && is_data_reg;
                evt.imiss    = !upd_hit && !is_data_reg;
                evt.wb       = upd_wb;
                evt.dacc     = is_data_reg;
                evt.iacc     = !is_data_reg;
                clock_next   = clock_reg + 1'b1;
                if (!upd_hit && cfg_rand_reg) begin
                    lfsr_next = lfsr_adv(lfsr_reg);
                end
                res_hit_next = upd_hit;
                res_way_next = upd_way;
                res_wb_next  = upd_wb;
                state_next   = ssac_pkg::ST_OUT;
            end
            ssac_pkg::ST_OUT: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    out_next     = {{PAD_W{1'b0}}, cnt.iacc, cnt.dacc, cnt.wb, cnt.imiss,
                                    cnt.dmiss, res_wb_reg, res_way_reg, res_hit_reg};
                    state_next   = ssac_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ssac_pkg::ST_CLEAR;
            end
        endcase

        // Configuration write to a listed index: store register, restart the clearing pass
        if (cfg_valid) begin
            unique case (cfg_index)
                ssac_pkg::CFG_OFFSET: cfg_off_next  = cfg_data[2:0];
                ssac_pkg::CFG_SETS:   cfg_sets_next = cfg_data[3:0];
                ssac_pkg::CFG_WAYS:   cfg_ways_next = cfg_data[1:0];
                ssac_pkg::CFG_POLICY: cfg_rand_next = cfg_data[0];
                ssac_pkg::CFG_SEED:   cfg_seed_next = cfg_data;
                default: ;
            endcase
            if (cfg_index == ssac_pkg::CFG_OFFSET || cfg_index == ssac_pkg::CFG_SETS ||
                cfg_index == ssac_pkg::CFG_WAYS || cfg_index == ssac_pkg::CFG_POLICY ||
                cfg_index == ssac_pkg::CFG_SEED) begin
                state_next   = ssac_pkg::ST_CLEAR;
                clr_idx_next = '0;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ssac_pkg::ST_CLEAR;
            clr_idx_reg  <= '0;
            cfg_off_reg  <= ssac_pkg::OFFSET_RST;
            cfg_sets_reg <= ssac_pkg::SETS_RST;
            cfg_ways_reg <= ssac_pkg::WAYS_RST;
            cfg_rand_reg <= ssac_pkg::POLICY_RST;
            cfg_seed_reg <= ssac_pkg::SEED_RST;
            m_valid_reg  <= 1'b0;
            cmp_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            cfg_off_reg  <= cfg_off_next;
            cfg_sets_reg <= cfg_sets_next;
            cfg_ways_reg <= cfg_ways_next;
            cfg_rand_reg <= cfg_rand_next;
            cfg_seed_reg <= cfg_seed_next;
            m_valid_reg  <= m_valid_next;
            cmp_vld_reg  <= cmp_vld_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        func_reg      <= func_next;
        addr_reg      <= addr_next;
        line_base_reg <= line_base_next;
        tag_reg       <= tag_next;
        is_data_reg   <= is_data_next;
        rnd_way_reg   <= rnd_way_next;
        rd_way_reg    <= rd_way_next;
        cmp_way_reg   <= cmp_way_next;
        lfsr_reg      <= lfsr_next;
        clock_reg     <= clock_next;
        res_hit_reg   <= res_hit_next;
        res_way_reg   <= res_way_next;
        res_wb_reg    <= res_wb_next;
        out_reg       <= out_next;
    end

    ssac_tag_ram #(
        .ADDR_W (RAM_AW),
        .DATA_W (WORD_W)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (ram_re),
        .rd_addr (ram_ra),
        .rd_data (ram_rd)
    );

    ssac_way_scan #(
        .TAG_W   (TAG_W),
        .STAMP_W (STAMP_WIDTH)
    ) u_way_scan (
        .aclk       (aclk),
        .start      (scan_start),
        .step       (cmp_vld_reg),
        .way        (cmp_way_reg),
        .line_valid (ram_rd[WORD_W-1]),
        .line_dirty (ram_rd[WORD_W-2]),
        .line_tag   (ram_rd[STAMP_WIDTH +: TAG_W]),
        .line_stamp (ram_rd[STAMP_WIDTH-1:0]),
        .tag        (tag_reg),
        .clock      (clock_reg),
        .rnd_way    (rnd_way_reg),
        .res        (scan_res)
    );

    ssac_counters u_counters (
        .aclk  (aclk),
        .clear (cnt_clear),
        .evt   (evt),
        .cnt   (cnt)
    );

    assign m_axis_tdata  = out_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign cfg_ready     = 1'b1;

endmodule

`default_nettype wire
